/* hw/rtl/secb_pkg.sv */
// Shared types and constants for the source event correlation blocker.
// No dependencies; the top and the checker refer to this package.
package secb_pkg;

	// action codes
	localparam logic [1:0] ACT_INGEST  = 2'd0;
	localparam logic [1:0] ACT_UNBLOCK = 2'd1;
	localparam logic [1:0] ACT_QUERY   = 2'd2;
	localparam logic [1:0] ACT_EXPIRE  = 2'd3;

	// outcome codes
	localparam logic [2:0] OUT_NONE     = 3'd0;
	localparam logic [2:0] OUT_BLOCKED  = 3'd1;
	localparam logic [2:0] OUT_FIRED    = 3'd2;
	localparam logic [2:0] OUT_BAD_KIND = 3'd3;
	localparam logic [2:0] OUT_FULL     = 3'd4;

	localparam logic [2:0] NO_RULE    = 3'd6;
	localparam int         RULE_COUNT = 6;
	localparam logic [3:0] KIND_COUNT = 4'd9;

	// event kinds
	localparam logic [3:0] K_SSH_FAIL  = 4'd0;
	localparam logic [3:0] K_SSH_OK    = 4'd1;
	localparam logic [3:0] K_WEB_SCAN  = 4'd2;
	localparam logic [3:0] K_WEB_EXPL  = 4'd3;
	localparam logic [3:0] K_WEB_AUTH  = 4'd4;
	localparam logic [3:0] K_DB_AUTH   = 4'd5;
	localparam logic [3:0] K_HONEYPOT  = 4'd6;
	localparam logic [3:0] K_SUDO_FAIL = 4'd7;
	localparam logic [3:0] K_SU_FAIL   = 4'd8;

	// correlation windows in seconds
	localparam logic [31:0] WIN_120  = 32'd120;
	localparam logic [31:0] WIN_180  = 32'd180;
	localparam logic [31:0] WIN_300  = 32'd300;
	localparam logic [31:0] WIN_600  = 32'd600;
	localparam logic [31:0] WIN_1800 = 32'd1800;

	// counter compare width and thresholds
	localparam int        CMPW     = 8;
	localparam logic [7:0] TH_WEB_AUTH = 8'd15;
	localparam logic [7:0] TH_TOTAL    = 8'd20;
	localparam logic [7:0] TH_SCAN     = 8'd5;
	localparam logic [7:0] TH_SSH      = 8'd3;
	localparam logic [7:0] TH_PAIR     = 8'd2;
	localparam logic [7:0] TH_ONE      = 8'd1;
	localparam logic [4:0] TH_KINDS    = 5'd4;

	// configuration register indexes and reset values
	localparam logic REG_DURATION = 1'b0;
	localparam logic REG_COOLDOWN = 1'b1;
	localparam logic [31:0] DURATION_RST = 32'd3600;
	localparam logic [15:0] COOLDOWN_RST = 16'd120;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] source_addr;
		logic [3:0]  event_kind;
		logic [31:0] now_sec;
	} req_t;

	typedef struct packed {
		logic [2:0]  outcome;
		logic [2:0]  rule_index;
		logic        hit;
		logic [31:0] remaining_sec;
	} rsp_t;

endpackage

/* hw/rtl/secb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module secb_ram #(
	parameter int W = 32,
	parameter int D = 256
) (
	input  logic                                clk,
	input  logic                                we,
	input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
	input  logic [W-1:0]                        wdata,
	input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
	output logic [W-1:0]                        rdata
);
	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

/* hw/rtl/source_event_correlation_blocker_top.sv */
// Top level of the source event correlation blocker.
// Depends on secb_pkg and secb_ram.
//
// Usage: a request transfer on req (req_valid/req_ready) carries one action:
// ingest an event, unblock, query or expire. Every request yields exactly one
// response transfer on rsp (rsp_valid/rsp_ready). Configuration (block duration
// at address 0, cooldown at address 4) is written over the APB port, by the user
// only while idle; the block itself does not enforce it. One request is worked
// on at a time; req_ready is high only in the idle state. Requests are served by
// walks of one entry per cycle over the block RAM, the source RAM and the event
// ring RAM, all through a single read port each. A finished response sits in
// the output register; a new request is taken while it waits, and the next
// response holds in the finish state until the receiver drains the register.
// Reset empties the source and block tables at once (counts and valid bits are
// cleared), so no clearing pass is needed.
module source_event_correlation_blocker_top #(
	parameter int MAX_SOURCES       = 256,
	parameter int EVENTS_PER_SOURCE = 64,
	parameter int BLOCK_ENTRIES     = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  secb_pkg::req_t     req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output secb_pkg::rsp_t     rsp,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	// widths
	localparam int SW   = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
	localparam int SCW  = $clog2(MAX_SOURCES + 1);
	localparam int EW   = $clog2(EVENTS_PER_SOURCE);
	localparam int FW   = $clog2(EVENTS_PER_SOURCE + 1);
	localparam int BW   = (BLOCK_ENTRIES > 1) ? $clog2(BLOCK_ENTRIES) : 1;
	localparam int BCW  = $clog2(BLOCK_ENTRIES + 1);
	localparam int ED   = MAX_SOURCES * EVENTS_PER_SOURCE;
	localparam int EAW  = $clog2(ED);
	localparam int LD   = MAX_SOURCES * secb_pkg::RULE_COUNT;
	localparam int LAW  = $clog2(LD);
	localparam int CW0  = (SCW > BCW) ? SCW : BCW;
	localparam int CW1  = (CW0 > FW) ? CW0 : FW;
	localparam int CW   = (CW1 > 3) ? CW1 : 3;
	localparam int MW   = EW + FW;
	localparam int CMPW = secb_pkg::CMPW;

	typedef enum logic [10:0] {
		S_IDLE   = 11'b00000000001,
		S_BSCAN  = 11'b00000000010,
		S_SSCAN  = 11'b00000000100,
		S_SNEW   = 11'b00000001000,
		S_MREAD  = 11'b00000010000,
		S_EWRITE = 11'b00000100000,
		S_ESCAN  = 11'b00001000000,
		S_LREAD  = 11'b00010000000,
		S_DECIDE = 11'b00100000000,
		S_BADD   = 11'b01000000000,
		S_FINISH = 11'b10000000000
	} state_t;

	state_t state_q;

	// configuration
	logic [31:0] dur_q;
	logic [15:0] cool_cfg_q;

	// latched request and pending response
	secb_pkg::req_t req_q;
	secb_pkg::rsp_t res_q;
	secb_pkg::rsp_t rsp_q;
	logic           rsp_valid_q;
	logic           do_expire_q;

	// tables held in flops
	logic [BLOCK_ENTRIES-1:0] blk_vld_q;
	logic [BCW-1:0]           blk_used_q;
	logic [SCW-1:0]           src_used_q;

	// walk counter and read pipeline
	logic [CW-1:0] scan_q;
	logic [CW-1:0] idx_s1;
	logic          pend_s1;
	logic [CW-1:0] limit;
	logic          issue;
	logic          scan_end;

	// block walk results
	logic          bfound_q;
	logic [BW-1:0] bidx_q;
	logic [31:0]   bexp_q;
	logic          free_found_q;
	logic [BW-1:0] free_idx_q;

	// source walk results
	logic          sfound_q;
	logic [SW-1:0] s_q;
	logic          new_q;
	logic [FW-1:0] fill_q;

	// ring walk counters
	logic [FW-1:0] c0_180_q, c6_180_q, c0_300_q, c5_300_q, c1_300_q, c78_300_q;
	logic [FW-1:0] c0_600_q, c23_600_q, c4_120_q, tot_q;
	logic [15:0]   kmask_q;
	logic [2:0]    grp_q;
	logic [secb_pkg::RULE_COUNT-1:0] cool_q;

	// RAM ports
	logic              src_we;
	logic [SW-1:0]     src_waddr;
	logic [31:0]       src_rdata;
	logic              meta_we;
	logic [MW-1:0]     meta_wdata;
	logic [MW-1:0]     meta_rdata;
	logic              evt_we;
	logic [EAW-1:0]    evt_waddr;
	logic [EAW-1:0]    evt_raddr;
	logic [35:0]       evt_rdata;
	logic              lft_we;
	logic [LAW-1:0]    lft_waddr;
	logic [32:0]       lft_wdata;
	logic [LAW-1:0]    lft_raddr;
	logic [32:0]       lft_rdata;
	logic              blk_we;
	logic [BW-1:0]     blk_waddr;
	logic [63:0]       blk_rdata;

	// derived values
	logic [EW-1:0]  pos_cur;
	logic [FW-1:0]  fill_cur;
	logic [EW-1:0]  pos_next;
	logic [FW-1:0]  fill_next;
	logic [EAW-1:0] ebase;
	logic [LAW-1:0] lbase;
	logic [secb_pkg::RULE_COUNT-1:0] met;
	logic [secb_pkg::RULE_COUNT-1:0] elig;
	logic [2:0]     rsel;
	logic [4:0]     nk;
	logic [32:0]    exp_sum;
	logic [31:0]    exp_sat;
	logic           src_room;
	logic           blk_room;

	// block walk per-entry view
	logic [31:0] b_exp;
	logic [31:0] b_addr;
	logic        b_v;
	logic        b_expiring;
	logic        b_live;

	// ring walk per-entry view
	logic [31:0] e_ts;
	logic [3:0]  e_k;
	logic [31:0] e_d;
	logic        e_ok;
	logic        w120, w180, w300, w600, w1800;

	// lft per-entry view
	logic [31:0] l_d;

	// ---------------------------------------------------------------- APB
	assign pready = 1'b1;
	always_comb begin
		prdata = (paddr[2] == secb_pkg::REG_COOLDOWN) ? {16'd0, cool_cfg_q} : dur_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dur_q      <= secb_pkg::DURATION_RST;
			cool_cfg_q <= secb_pkg::COOLDOWN_RST;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == secb_pkg::REG_COOLDOWN) begin
				cool_cfg_q <= pwdata[15:0];
			end else begin
				dur_q <= pwdata;
			end
		end
	end

	// ---------------------------------------------------------------- RAMs
	secb_ram #(.W(32), .D(MAX_SOURCES)) u_src_ram (
		.clk(clk), .we(src_we), .waddr(src_waddr), .wdata(req_q.source_addr),
		.raddr(scan_q[SW-1:0]), .rdata(src_rdata)
	);

	secb_ram #(.W(MW), .D(MAX_SOURCES)) u_meta_ram (
		.clk(clk), .we(meta_we), .waddr(s_q), .wdata(meta_wdata),
		.raddr(s_q), .rdata(meta_rdata)
	);

	secb_ram #(.W(36), .D(ED)) u_evt_ram (
		.clk(clk), .we(evt_we), .waddr(evt_waddr), .wdata({req_q.event_kind, req_q.now_sec}),
		.raddr(evt_raddr), .rdata(evt_rdata)
	);

	secb_ram #(.W(33), .D(LD)) u_lft_ram (
		.clk(clk), .we(lft_we), .waddr(lft_waddr), .wdata(lft_wdata),
		.raddr(lft_raddr), .rdata(lft_rdata)
	);

	secb_ram #(.W(64), .D(BLOCK_ENTRIES)) u_blk_ram (
		.clk(clk), .we(blk_we), .waddr(blk_waddr), .wdata({req_q.source_addr, exp_sat}),
		.raddr(scan_q[BW-1:0]), .rdata(blk_rdata)
	);

	// ---------------------------------------------------------------- datapath
	always_comb begin
		unique case (state_q)
			S_BSCAN: limit = CW'(blk_used_q);
			S_SSCAN: limit = CW'(src_used_q);
			S_ESCAN: limit = CW'(fill_q);
			S_LREAD: limit = CW'(secb_pkg::RULE_COUNT);
			default: limit = '0;
		endcase
	end

	assign issue    = scan_q < limit;
	assign scan_end = !issue && !pend_s1;

	assign src_room = src_used_q < SCW'(MAX_SOURCES);
	assign blk_room = blk_used_q < BCW'(BLOCK_ENTRIES);

	assign ebase = EAW'(s_q) * EAW'(EVENTS_PER_SOURCE);
	assign lbase = LAW'(s_q) * LAW'(secb_pkg::RULE_COUNT);

	// ring position: a new source starts empty
	assign pos_cur   = new_q ? '0 : meta_rdata[MW-1:FW];
	assign fill_cur  = new_q ? '0 : meta_rdata[FW-1:0];
	assign pos_next  = (pos_cur == EW'(EVENTS_PER_SOURCE - 1)) ? '0 : pos_cur + 1'b1;
	assign fill_next = (fill_cur < FW'(EVENTS_PER_SOURCE)) ? fill_cur + 1'b1 : fill_cur;

	assign exp_sum = {1'b0, req_q.now_sec} + {1'b0, dur_q};
	assign exp_sat = exp_sum[32] ? 32'hFFFF_FFFF : exp_sum[31:0];

	// block entry being checked
	assign b_exp      = blk_rdata[31:0];
	assign b_addr     = blk_rdata[63:32];
	assign b_v        = blk_vld_q[idx_s1[BW-1:0]];
	assign b_expiring = do_expire_q && b_v && (req_q.now_sec >= b_exp);
	assign b_live     = b_v && !b_expiring;

	// ring entry being checked
	assign e_ts  = evt_rdata[31:0];
	assign e_k   = evt_rdata[35:32];
	assign e_d   = req_q.now_sec - e_ts;
	assign e_ok  = e_ts <= req_q.now_sec;
	assign w120  = e_ok && (e_d <= secb_pkg::WIN_120);
	assign w180  = e_ok && (e_d <= secb_pkg::WIN_180);
	assign w300  = e_ok && (e_d <= secb_pkg::WIN_300);
	assign w600  = e_ok && (e_d <= secb_pkg::WIN_600);
	assign w1800 = e_ok && (e_d <= secb_pkg::WIN_1800);

	assign l_d = req_q.now_sec - lft_rdata[31:0];

	always_comb begin
		nk = '0;
		for (int i = 0; i < 16; i++) begin
			nk = nk + 5'(kmask_q[i]);
		end
	end

	always_comb begin
		met[0] = (CMPW'(c6_180_q) >= secb_pkg::TH_ONE) && (CMPW'(c0_180_q) >= secb_pkg::TH_ONE);
		met[1] = (CMPW'(c0_300_q) >= secb_pkg::TH_SSH) && (CMPW'(c5_300_q) >= secb_pkg::TH_PAIR);
		met[2] = (CMPW'(c23_600_q) >= secb_pkg::TH_SCAN) && (CMPW'(c0_600_q) >= secb_pkg::TH_SSH);
		met[3] = (CMPW'(c1_300_q) >= secb_pkg::TH_ONE) && (CMPW'(c78_300_q) >= secb_pkg::TH_PAIR);
		met[4] = CMPW'(c4_120_q) >= secb_pkg::TH_WEB_AUTH;
		met[5] = (CMPW'(tot_q) >= secb_pkg::TH_TOTAL) && (nk >= secb_pkg::TH_KINDS) &&
			(grp_q == 3'b111);
	end

	// first eligible rule in priority order
	assign elig = met & ~cool_q;
	always_comb begin
		rsel = secb_pkg::NO_RULE;
		for (int r = secb_pkg::RULE_COUNT - 1; r >= 0; r--) begin
			if (elig[r]) begin
				rsel = 3'(r);
			end
		end
	end

	// RAM write and read controls
	always_comb begin
		src_we     = (state_q == S_SSCAN) && scan_end && !sfound_q && src_room;
		src_waddr  = src_used_q[SW-1:0];
		meta_we    = ((state_q == S_SNEW) && (scan_q == '0)) || (state_q == S_EWRITE);
		meta_wdata = (state_q == S_EWRITE) ? {pos_next, fill_next} : '0;
		evt_we     = state_q == S_EWRITE;
		evt_waddr  = ebase + EAW'(pos_cur);
		evt_raddr  = ebase + EAW'(scan_q[EW-1:0]);
		lft_we     = (state_q == S_SNEW) || ((state_q == S_DECIDE) && (elig != '0));
		lft_waddr  = lbase + LAW'((state_q == S_SNEW) ? scan_q[2:0] : rsel);
		lft_wdata  = (state_q == S_SNEW) ? 33'd0 : {1'b1, req_q.now_sec};
		lft_raddr  = lbase + LAW'(scan_q[2:0]);
		blk_we     = (state_q == S_BADD) && (free_found_q || blk_room);
		blk_waddr  = free_found_q ? free_idx_q : blk_used_q[BW-1:0];
	end

	// ---------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			blk_vld_q   <= '0;
			blk_used_q  <= '0;
			src_used_q  <= '0;
			pend_s1     <= 1'b0;
			scan_q      <= '0;
		end else begin
			// load the output register when free, drain it on a transfer
			if ((state_q == S_FINISH) && (!rsp_valid_q || rsp_ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end

			// advance the walk; one read a cycle
			if (issue) begin
				scan_q  <= scan_q + 1'b1;
				idx_s1  <= scan_q;
				pend_s1 <= 1'b1;
			end else begin
				pend_s1 <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						req_q               <= req;
						res_q.outcome       <= ((req.action == secb_pkg::ACT_INGEST) &&
							(req.event_kind >= secb_pkg::KIND_COUNT)) ?
							secb_pkg::OUT_BAD_KIND : secb_pkg::OUT_NONE;
						res_q.rule_index    <= secb_pkg::NO_RULE;
						res_q.hit           <= 1'b0;
						res_q.remaining_sec <= '0;
						do_expire_q  <= (req.action == secb_pkg::ACT_INGEST) ||
							(req.action == secb_pkg::ACT_EXPIRE);
						bfound_q     <= 1'b0;
						free_found_q <= 1'b0;
						scan_q       <= '0;
						if ((req.action == secb_pkg::ACT_INGEST) &&
							(req.event_kind >= secb_pkg::KIND_COUNT)) begin
							state_q <= S_FINISH;
						end else begin
							state_q <= S_BSCAN;
						end
					end
				end

				S_BSCAN: begin
					// expire due entries (ingest and expire only), look up the address and note the first free slot
					if (pend_s1) begin
						if (b_expiring) begin
							blk_vld_q[idx_s1[BW-1:0]] <= 1'b0;
						end
						if (b_live && (b_addr == req_q.source_addr) && !bfound_q) begin
							bfound_q <= 1'b1;
							bidx_q   <= idx_s1[BW-1:0];
							bexp_q   <= b_exp;
						end
						if (!b_live && !free_found_q) begin
							free_found_q <= 1'b1;
							free_idx_q   <= idx_s1[BW-1:0];
						end
					end
					if (scan_end) begin
						scan_q <= '0;
						unique case (req_q.action)
							secb_pkg::ACT_INGEST: begin
								if (bfound_q) begin
									res_q.outcome <= secb_pkg::OUT_BLOCKED;
									state_q       <= S_FINISH;
								end else begin
									sfound_q <= 1'b0;
									state_q  <= S_SSCAN;
								end
							end
							secb_pkg::ACT_UNBLOCK: begin
								res_q.hit <= bfound_q;
								if (bfound_q) begin
									blk_vld_q[bidx_q] <= 1'b0;
								end
								state_q <= S_FINISH;
							end
							secb_pkg::ACT_QUERY: begin
								res_q.hit <= bfound_q;
								if (bfound_q && (bexp_q > req_q.now_sec)) begin
									res_q.remaining_sec <= bexp_q - req_q.now_sec;
								end
								state_q <= S_FINISH;
							end
							default: begin
								state_q <= S_FINISH;
							end
						endcase
					end
				end

				S_SSCAN: begin
					if (pend_s1 && !sfound_q && (src_rdata == req_q.source_addr)) begin
						sfound_q <= 1'b1;
						s_q      <= idx_s1[SW-1:0];
					end
					if (scan_end) begin
						scan_q <= '0;
						if (sfound_q) begin
							new_q   <= 1'b0;
							state_q <= S_MREAD;
						end else if (src_room) begin
							// create the source; its rule stamps are cleared next
							s_q        <= src_used_q[SW-1:0];
							src_used_q <= src_used_q + 1'b1;
							new_q      <= 1'b1;
							state_q    <= S_SNEW;
						end else begin
							res_q.outcome <= secb_pkg::OUT_FULL;
							state_q       <= S_FINISH;
						end
					end
				end

				S_SNEW: begin
					if (scan_q == CW'(secb_pkg::RULE_COUNT - 1)) begin
						state_q <= S_EWRITE;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end

				S_MREAD: begin
					state_q <= S_EWRITE;
				end

				S_EWRITE: begin
					fill_q    <= fill_next;
					scan_q    <= '0;
					c0_180_q  <= '0;
					c6_180_q  <= '0;
					c0_300_q  <= '0;
					c5_300_q  <= '0;
					c1_300_q  <= '0;
					c78_300_q <= '0;
					c0_600_q  <= '0;
					c23_600_q <= '0;
					c4_120_q  <= '0;
					tot_q     <= '0;
					kmask_q   <= '0;
					grp_q     <= '0;
					state_q   <= S_ESCAN;
				end

				S_ESCAN: begin
					if (pend_s1) begin
						if (w180 && (e_k == secb_pkg::K_SSH_FAIL))  c0_180_q <= c0_180_q + 1'b1;
						if (w180 && (e_k == secb_pkg::K_HONEYPOT))  c6_180_q <= c6_180_q + 1'b1;
						if (w300 && (e_k == secb_pkg::K_SSH_FAIL))  c0_300_q <= c0_300_q + 1'b1;
						if (w300 && (e_k == secb_pkg::K_DB_AUTH))   c5_300_q <= c5_300_q + 1'b1;
						if (w300 && (e_k == secb_pkg::K_SSH_OK))    c1_300_q <= c1_300_q + 1'b1;
						if (w300 && ((e_k == secb_pkg::K_SUDO_FAIL) ||
							(e_k == secb_pkg::K_SU_FAIL)))
							c78_300_q <= c78_300_q + 1'b1;
						if (w600 && (e_k == secb_pkg::K_SSH_FAIL))  c0_600_q <= c0_600_q + 1'b1;
						if (w600 && ((e_k == secb_pkg::K_WEB_SCAN) ||
							(e_k == secb_pkg::K_WEB_EXPL)))
							c23_600_q <= c23_600_q + 1'b1;
						if (w120 && (e_k == secb_pkg::K_WEB_AUTH))  c4_120_q <= c4_120_q + 1'b1;
						if (w1800) begin
							tot_q        <= tot_q + 1'b1;
							kmask_q[e_k] <= 1'b1;
							if (e_k <= secb_pkg::K_SSH_OK) begin
								grp_q[0] <= 1'b1;
							end else if (e_k <= secb_pkg::K_WEB_AUTH) begin
								grp_q[1] <= 1'b1;
							end else begin
								grp_q[2] <= 1'b1;
							end
						end
					end
					if (scan_end) begin
						scan_q  <= '0;
						state_q <= S_LREAD;
					end
				end

				S_LREAD: begin
					// a rule cools down while now lies within cooldown of its stamp
					if (pend_s1) begin
						cool_q[idx_s1[2:0]] <= lft_rdata[32] &&
							(req_q.now_sec >= lft_rdata[31:0]) &&
							(l_d < {16'd0, cool_cfg_q});
					end
					if (scan_end) begin
						state_q <= S_DECIDE;
					end
				end

				S_DECIDE: begin
					if (elig != '0) begin
						res_q.outcome    <= secb_pkg::OUT_FIRED;
						res_q.rule_index <= rsel;
						state_q          <= S_BADD;
					end else begin
						state_q <= S_FINISH;
					end
				end

				S_BADD: begin
					// reuse a freed slot, else append; drop when full
					if (free_found_q) begin
						blk_vld_q[free_idx_q] <= 1'b1;
					end else if (blk_room) begin
						blk_vld_q[blk_used_q[BW-1:0]] <= 1'b1;
						blk_used_q <= blk_used_q + 1'b1;
					end
					state_q <= S_FINISH;
				end

				S_FINISH: begin
					// hold until the output register is free
					if (!rsp_valid_q || rsp_ready) begin
						rsp_q   <= res_q;
						state_q <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_ready = state_q == S_IDLE;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* hw/rtl/secb_chk.sv */
// Port-level checker for the source event correlation blocker, bound to the top.
// Depends on secb_pkg.
module secb_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input secb_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input secb_pkg::rsp_t rsp
);
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_ready |=> req_valid && $stable(req))
		else $error("request dropped or changed while stalled");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response dropped or changed while stalled");

	a_rule_fired: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.outcome == secb_pkg::OUT_FIRED) |->
			rsp.rule_index != secb_pkg::NO_RULE)
		else $error("fired outcome without a rule");

	a_rule_none: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.outcome != secb_pkg::OUT_FIRED) |->
			rsp.rule_index == secb_pkg::NO_RULE)
		else $error("rule index set without a firing");

	a_hit_only_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.hit || (rsp.remaining_sec != '0)) |->
			rsp.outcome == secb_pkg::OUT_NONE)
		else $error("lookup fields mixed with an ingest outcome");
endmodule

bind source_event_correlation_blocker_top secb_chk u_secb_chk (.*);
